/* rtl/core/isqrt_pkg.sv */
// isqrt_pkg: types and constants shared by the integer square root block.
// Used by isqrt_ctrl, isqrt_dp and integer_square_root. No dependencies.
package isqrt_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int ROOT_WIDTH  = 16;
   localparam int STEP_WIDTH  = 2;

   // Newton step numbering, 0 to 3; step two rounds up.
   localparam logic [STEP_WIDTH-1:0] ROUND_STEP = 2'd2;
   localparam logic [STEP_WIDTH-1:0] LAST_STEP  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEED,
      ST_DIV_START,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic seed_small;
      logic est_step;
      logic div_start;
      logic update;
      logic add_one;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic trivial;
      logic est_last;
      logic div_done;
   } dp_status_type;

endpackage

/* rtl/core/integer_square_root.sv */
// integer_square_root: top level, controller plus datapath.
// Depends on isqrt_pkg, isqrt_ctrl, isqrt_dp (and isqrt_div below it).
//
// Usage:
//   req_* carries one operand per beat: the low DATA_WIDTH bits of req_tdata,
//   read as two's complement. rsp_* returns one root per operand, in order.
//   Zero or negative gives 0, one to three gives 1; larger operands run a
//   seed search (the estimate doubles for each pair of operand bits above the lowest pair)
//   and four Newton steps, each a division on the shared radix-4 divider.
// One operand is in work at a time; req_tready is high only while idle.
// The result sits in an output register; a new operand is taken while it
// waits, and a finished result is held until rsp_tready takes it.
// Reset (synchronous) drops any operand in work and any pending result.
module integer_square_root #(
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [15:0] root
);

   isqrt_pkg::ctrl_cmd_type  cmd;
   isqrt_pkg::dp_status_type status;

   isqrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   isqrt_dp #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .value  (req_tdata),
      .cmd    (cmd),
      .status (status),
      .root   (rsp_tdata)
   );

endmodule

/* rtl/core/isqrt_div.sv */
// isqrt_div: unsigned restoring divider, two quotient bits per cycle.
// Standalone; instantiated by isqrt_dp. A zero divisor gives quotient 0.
module isqrt_div #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient
);

   localparam int PAD_WIDTH = DATA_WIDTH + (DATA_WIDTH % 2);
   localparam int STEPS     = PAD_WIDTH / 2;
   localparam int CNT_WIDTH = $clog2(STEPS + 1);

   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [PAD_WIDTH-1:0]  quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic                  dzero_ff, dzero_in;

   logic [DATA_WIDTH:0]   den_ext;
   logic [DATA_WIDTH:0]   part_a, part_b, sub_a, sub_b;
   logic                  ge_a, ge_b;

   always_comb begin
      den_ext = {1'b0, den_ff};
      part_a  = {rem_ff, quo_ff[PAD_WIDTH-1]};
      ge_a    = part_a >= den_ext;
      sub_a   = ge_a ? (part_a - den_ext) : part_a;
      part_b  = {sub_a[DATA_WIDTH-1:0], quo_ff[PAD_WIDTH-2]};
      ge_b    = part_b >= den_ext;
      sub_b   = ge_b ? (part_b - den_ext) : part_b;
   end

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      dzero_in = dzero_ff;
      if (start) begin
         rem_in   = '0;
         quo_in   = PAD_WIDTH'(dividend);
         den_in   = divisor;
         dzero_in = (divisor == '0);
         cnt_in   = CNT_WIDTH'(STEPS);
         run_in   = 1'b1;
      end else if (run_ff) begin
         rem_in = sub_b[DATA_WIDTH-1:0];
         quo_in = {quo_ff[PAD_WIDTH-3:0], ge_a, ge_b};
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      dzero_ff <= dzero_in;
   end

   assign done     = done_ff;
   assign quotient = dzero_ff ? '0 : quo_ff[DATA_WIDTH-1:0];

endmodule

/* rtl/core/isqrt_dp.sv */
// isqrt_dp: operand, estimate and result registers with the shared divider.
// Depends on isqrt_pkg and isqrt_div; driven by commands from isqrt_ctrl.
module isqrt_dp #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [isqrt_pkg::VALUE_WIDTH-1:0]    value,
   input  isqrt_pkg::ctrl_cmd_type              cmd,
   output isqrt_pkg::dp_status_type             status,
   output logic [isqrt_pkg::ROOT_WIDTH-1:0]     root
);

   logic [DATA_WIDTH-1:0] v_ff, v_in;
   logic [DATA_WIDTH-1:0] j_ff, j_in;
   logic [DATA_WIDTH-1:0] e_ff, e_in;
   logic                  nonpos_ff, nonpos_in;
   logic                  trivial_ff, trivial_in;
   logic [isqrt_pkg::ROOT_WIDTH-1:0] root_ff, root_in;

   logic [DATA_WIDTH-1:0] v_new;
   logic [DATA_WIDTH-1:0] j_next;
   logic                  est_last;
   logic [DATA_WIDTH-1:0] quot;
   logic                  div_done;
   logic [DATA_WIDTH:0]   sum;

   isqrt_div #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (v_ff),
      .divisor  (e_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      v_new    = value[DATA_WIDTH-1:0];
      j_next   = j_ff >> 2;
      est_last = (j_next == '0);
      sum      = {1'b0, e_ff} + {1'b0, quot} + (DATA_WIDTH+1)'(cmd.add_one);
   end

   always_comb begin
      v_in       = v_ff;
      j_in       = j_ff;
      e_in       = e_ff;
      nonpos_in  = nonpos_ff;
      trivial_in = trivial_ff;
      root_in    = root_ff;
      if (cmd.load) begin
         v_in       = v_new;
         j_in       = v_new;
         e_in       = DATA_WIDTH'(1);
         nonpos_in  = v_new[DATA_WIDTH-1] | (v_new == '0);
         trivial_in = v_new[DATA_WIDTH-1] | (v_new <= DATA_WIDTH'(3));
      end
      if (cmd.seed_small) begin
         e_in = nonpos_ff ? '0 : DATA_WIDTH'(1);
      end
      if (cmd.est_step) begin
         if (est_last) begin
            e_in = e_ff - DATA_WIDTH'(1);
         end else begin
            j_in = j_next;
            e_in = e_ff << 1;
         end
      end
      if (cmd.update) begin
         e_in = sum[DATA_WIDTH:1];
      end
      if (cmd.out_load) begin
         root_in = isqrt_pkg::ROOT_WIDTH'(e_ff);
      end
   end

   always_ff @(posedge clock) begin
      v_ff       <= v_in;
      j_ff       <= j_in;
      e_ff       <= e_in;
      nonpos_ff  <= nonpos_in;
      trivial_ff <= trivial_in;
      root_ff    <= root_in;
   end

   assign status.trivial  = trivial_ff;
   assign status.est_last = est_last;
   assign status.div_done = div_done;
   assign root            = root_ff;

endmodule

/* rtl/core/isqrt_ctrl.sv */
// isqrt_ctrl: sequencer for seed search, four Newton steps and result beat.
// Depends on isqrt_pkg; commands isqrt_dp and owns the output valid flag.
module isqrt_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  isqrt_pkg::dp_status_type    status,
   output isqrt_pkg::ctrl_cmd_type     cmd
);

   isqrt_pkg::state_type state_ff, state_in;
   logic [isqrt_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         isqrt_pkg::ST_IDLE: begin
            step_in = '0;
            if (req_valid) state_in = isqrt_pkg::ST_CHECK;
         end
         isqrt_pkg::ST_CHECK: begin
            state_in = status.trivial ? isqrt_pkg::ST_FINISH : isqrt_pkg::ST_SEED;
         end
         isqrt_pkg::ST_SEED: begin
            if (status.est_last) state_in = isqrt_pkg::ST_DIV_START;
         end
         isqrt_pkg::ST_DIV_START: begin
            state_in = isqrt_pkg::ST_DIV;
         end
         isqrt_pkg::ST_DIV: begin
            if (status.div_done) begin
               step_in = step_ff + isqrt_pkg::STEP_WIDTH'(1);
               if (step_ff == isqrt_pkg::LAST_STEP) state_in = isqrt_pkg::ST_FINISH;
               else state_in = isqrt_pkg::ST_DIV_START;
            end
         end
         isqrt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = isqrt_pkg::ST_IDLE;
         end
         default: begin
            state_in = isqrt_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.load       = (state_ff == isqrt_pkg::ST_IDLE) && req_valid;
      cmd.seed_small = (state_ff == isqrt_pkg::ST_CHECK) && status.trivial;
      cmd.est_step   = (state_ff == isqrt_pkg::ST_SEED);
      cmd.div_start  = (state_ff == isqrt_pkg::ST_DIV_START);
      cmd.update     = (state_ff == isqrt_pkg::ST_DIV) && status.div_done;
      cmd.add_one    = (step_ff == isqrt_pkg::ROUND_STEP);
      cmd.out_load   = (state_ff == isqrt_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);
      req_ready      = (state_ff == isqrt_pkg::ST_IDLE);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= isqrt_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for integer_square_root, with a root predictor and a scoreboard.
// Drives operand beats and checks root beats under random idling and a long output stall.
// Depends on integer_square_root, the modules below it and isqrt_pkg; no other files are needed.
module tb;

   localparam int DATA_WIDTH   = 32;
   localparam int RANDOM_ITEMS = 1100;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 120;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      logic [31:0] value;
      logic [15:0] root;
   } root_beat_type;

   class root_scoreboard;
      root_beat_type pending_roots[$];
      int            mismatch_count = 0;

      function logic [63:0] quotient(logic [63:0] num, logic [63:0] den);
         return (den == 0) ? 64'd0 : num / den;
      endfunction

      function logic [15:0] predict_root(logic [31:0] value);
         logic [63:0] raw;
         logic [63:0] shifted;
         logic [63:0] est;
         int          shifts;
         raw = {32'd0, value} & ((64'd1 << DATA_WIDTH) - 64'd1);
         if (raw[DATA_WIDTH-1] || raw == 0) return 16'd0;
         if (raw <= 3) return 16'd1;
         shifts  = 0;
         shifted = raw >> 2;
         while (shifted != 0) begin
            shifts++;
            shifted = shifted >> 2;
         end
         est = ((64'd1 << shifts) - 64'd1) & 64'hFFFF_FFFF;
         est = (est + quotient(raw, est)) >> 1;
         est = (est + quotient(raw, est)) >> 1;
         est = (64'd1 + est + quotient(raw, est)) >> 1;
         est = (est + quotient(raw, est)) >> 1;
         return est[15:0];
      endfunction

      function void note_operand(logic [31:0] value);
         root_beat_type beat;
         beat.value = value;
         beat.root  = predict_root(value);
         pending_roots.push_back(beat);
      endfunction

      function void check_root(logic [15:0] root);
         root_beat_type beat;
         if (pending_roots.size() == 0) begin
            $display("%0t: unexpected root beat: expected none, actual %0d", $time, root);
            mismatch_count++;
            return;
         end
         beat = pending_roots.pop_front();
         if (root !== beat.root) begin
            $display("%0t: root mismatch for operand %h: expected %0d, actual %0d",
                     $time, beat.value, beat.root, root);
            mismatch_count++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = 32'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   int cycle_count    = 0;

   root_scoreboard board = new();

   integer_square_root #(
      .DATA_WIDTH(DATA_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: check, then pick tready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_root(rsp_tdata);
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         rsp_tready   <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic send_operand(input logic [31:0] value);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      board.note_operand(value);
   endtask

   function automatic logic [31:0] random_operand();
      int unsigned n;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 20);
         2: return $urandom >> $urandom_range(1, 31);
         3: begin
            n = $urandom_range(0, 46341);
            return n * n + $urandom_range(0, 2) - 1;
         end
         4: return 32'h8000_0000 | $urandom;
         default: return {1'b0, $urandom} >> 1;
      endcase
   endfunction

   task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                            input bit with_hold);
      send_idle_pct  <= idle_pct;
      recv_stall_pct <= stall_pct;
      for (int i = 0; i < count; i++) begin
         if (with_hold && i == count / 3) hold_requests <= hold_requests + 1;
         send_operand(random_operand());
      end
   endtask

   initial begin
      logic [31:0] directed[$];
      directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd15, 32'd16, 32'd17,
                   32'd24, 32'd25, 32'd255, 32'd256, 32'h0000_FFFF, 32'h0001_0000,
                   32'h3FFF_FFFF, 32'h4000_0000, 32'd2147395599, 32'd2147395600,
                   32'd2147395601, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFE};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_operand(directed[i]);
      run_phase(0, 0, RANDOM_ITEMS / 4, 1'b1);
      run_phase(60, 0, RANDOM_ITEMS / 4, 1'b0);
      run_phase(0, 60, RANDOM_ITEMS / 4, 1'b0);
      run_phase(31, 31, RANDOM_ITEMS / 4, 1'b0);
      req_tvalid <= 1'b0;
      while (board.pending_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
